[design/mfw_pkg.sv]
package mfw_pkg;

   localparam int OFFSET_FRAC_BITS_DEF = 12;
   localparam int WEIGHT_FRAC_BITS_DEF = 15;

   localparam int FIELD_W    = 16;
   localparam int CSR_IDX_W  = 2;

   // Scaled offset t is unsigned with T_FRAC fraction bits and saturates at 2.0.
   localparam int T_FRAC     = 16;
   localparam int T_W        = 18;
   localparam int T2_W       = 19;
   localparam int T3_W       = 20;

   // Polynomial coefficients in Q.15; the widest one is -12*b - 48*c.
   localparam int COEF_W     = 23;
   localparam int SUM_W      = 44;

   // The 6 * 2^11 divide is an arithmetic shift followed by a divide by three.
   localparam int DIV_SHIFT  = 12;
   localparam int U_W        = 32;
   localparam int RECIP_SH   = 33;
   localparam int QUOT_W     = 2 * U_W - RECIP_SH;
   localparam int KV_W       = 30;
   localparam int PROD_W     = 2 * KV_W;

   localparam int QUEUE_DEPTH = 2;

   localparam logic [T_W-1:0]    T_ONE       = T_W'(1) << T_FRAC;
   localparam logic [T_W-1:0]    T_MAX       = T_W'(2) << T_FRAC;
   localparam logic [U_W-1:0]    DIV3_BIAS   = 32'hC000_0000;
   localparam logic [U_W-1:0]    DIV3_RECIP  = 32'hAAAA_AAAB;
   localparam logic [QUOT_W-1:0] DIV3_OFFSET = QUOT_W'(1) << 30;

   localparam logic [FIELD_W-1:0] INV_RADIUS_RESET = 16'd16384;
   localparam logic [FIELD_W-1:0] THIRD_Q15        = 16'd10923;

   localparam logic [COEF_W-1:0] INNER_A_BASE  = COEF_W'(393216);
   localparam logic [COEF_W-1:0] INNER_BB_BASE = COEF_W'(-589824);
   localparam logic [COEF_W-1:0] INNER_DD_BASE = COEF_W'(196608);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_INV_RADIUS_X = 2'd0,
      CSR_INV_RADIUS_Y = 2'd1,
      CSR_BLUR_B       = 2'd2,
      CSR_RING_C       = 2'd3
   } csr_idx_type;

   typedef struct packed {
      logic signed [COEF_W-1:0] a;
      logic signed [COEF_W-1:0] bb;
      logic signed [COEF_W-1:0] cc;
      logic signed [COEF_W-1:0] dd;
   } coef_set_type;

   typedef struct packed {
      logic [FIELD_W-1:0] inv_x;
      logic [FIELD_W-1:0] inv_y;
      coef_set_type       outer;
      coef_set_type       inner;
   } csr_cfg_type;

   typedef struct packed {
      logic [T_W-1:0] t_x;
      logic [T_W-1:0] t_y;
   } qentry_type;

endpackage

[design/mitchell_filter_weight_2d.sv]
// Separable Mitchell-Netravali filter weight for a sample offset (dx, dy).
//
// Requests: drive req_dx and req_dy (signed, OFFSET_FRAC_BITS fraction bits)
// and raise req_start. A request is taken at a rising edge where req_start is
// high and req_busy is low. The back end drains one request per cycle, so
// req_busy stays low in normal use and a new request may follow every cycle.
//
// Results: rsp_valid is high for exactly one cycle with rsp_weight (signed,
// WEIGHT_FRAC_BITS fraction bits). The strobe follows the request through
// the queue and the back-end pipeline; results leave in request order at
// one per cycle. The receiver cannot stall the block; nothing is held back.
//
// Configuration: registers are written over the csr_ port, which is always
// ready. Write them only while no request is in flight. The coefficients are
// re-derived in the cycle after a write.
//
// Reset (synchronous, active high) empties the request queue and pipeline and
// loads the default radii and B = C = 1/3.
module mitchell_filter_weight_2d import mfw_pkg::*; #(
   parameter int OFFSET_FRAC_BITS = OFFSET_FRAC_BITS_DEF,
   parameter int WEIGHT_FRAC_BITS = WEIGHT_FRAC_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_start,
   output logic                      req_busy,
   input  logic signed [FIELD_W-1:0] req_dx,
   input  logic signed [FIELD_W-1:0] req_dy,
   output logic                      rsp_valid,
   output logic signed [FIELD_W-1:0] rsp_weight,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [FIELD_W-1:0]        csr_data
);

   csr_cfg_type cfg;
   qentry_type  wr_entry;
   qentry_type  head;
   logic        push;
   logic        pop;
   logic        full;
   logic        head_valid;

   mfw_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   mfw_front #(
      .OFFSET_FRAC_BITS (OFFSET_FRAC_BITS)
   ) u_front (
      .req_start (req_start),
      .full      (full),
      .req_dx    (req_dx),
      .req_dy    (req_dy),
      .cfg       (cfg),
      .push      (push),
      .entry     (wr_entry)
   );

   mfw_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .wr_entry   (wr_entry),
      .pop        (pop),
      .full       (full),
      .head_valid (head_valid),
      .head       (head)
   );

   mfw_back #(
      .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .cfg        (cfg),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_weight (rsp_weight)
   );

   assign req_busy = full;

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (req_start && !req_busy) |-> ##8 rsp_valid)
      else $error("accepted request produced no result");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(req_start && !req_busy, 8))
      else $error("result without a matching request");

endmodule

[design/mfw_csr.sv]
module mfw_csr import mfw_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [FIELD_W-1:0]   csr_data,
   output csr_cfg_type          cfg
);

   logic [FIELD_W-1:0] inv_x_ff, inv_x_in;
   logic [FIELD_W-1:0] inv_y_ff, inv_y_in;
   logic [FIELD_W-1:0] blur_b_ff, blur_b_in;
   logic [FIELD_W-1:0] ring_c_ff, ring_c_in;
   coef_set_type       outer_ff, outer_in;
   coef_set_type       inner_ff, inner_in;
   logic [FIELD_W-1:0] b_eff;
   logic [FIELD_W-1:0] c_eff;
   logic [COEF_W-1:0]  bw;
   logic [COEF_W-1:0]  cw;

   assign csr_ready = 1'b1;

   always_comb begin
      inv_x_in  = inv_x_ff;
      inv_y_in  = inv_y_ff;
      blur_b_in = blur_b_ff;
      ring_c_in = ring_c_ff;
      if (csr_valid) begin
         unique case (csr_idx_type'(csr_index))
            CSR_INV_RADIUS_X: inv_x_in  = csr_data;
            CSR_INV_RADIUS_Y: inv_y_in  = csr_data;
            CSR_BLUR_B:       blur_b_in = csr_data;
            CSR_RING_C:       ring_c_in = csr_data;
         endcase
      end
   end

   // A zero B or C selects the default of one third for both.
   always_comb begin
      if ((blur_b_ff == '0) || (ring_c_ff == '0)) begin
         b_eff = THIRD_Q15;
         c_eff = THIRD_Q15;
      end else begin
         b_eff = blur_b_ff;
         c_eff = ring_c_ff;
      end
      bw = COEF_W'(b_eff);
      cw = COEF_W'(c_eff);
      // Two's complement arithmetic modulo 2^COEF_W; every coefficient fits.
      outer_in.a  = COEF_W'(0) - bw - COEF_W'(6) * cw;
      outer_in.bb = COEF_W'(6) * bw + COEF_W'(30) * cw;
      outer_in.cc = COEF_W'(0) - COEF_W'(12) * bw - COEF_W'(48) * cw;
      outer_in.dd = COEF_W'(8) * bw + COEF_W'(24) * cw;
      inner_in.a  = INNER_A_BASE - COEF_W'(9) * bw - COEF_W'(6) * cw;
      inner_in.bb = INNER_BB_BASE + COEF_W'(12) * bw + COEF_W'(6) * cw;
      inner_in.cc = '0;
      inner_in.dd = INNER_DD_BASE - COEF_W'(2) * bw;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_x_ff  <= INV_RADIUS_RESET;
         inv_y_ff  <= INV_RADIUS_RESET;
         blur_b_ff <= THIRD_Q15;
         ring_c_ff <= THIRD_Q15;
      end else begin
         inv_x_ff  <= inv_x_in;
         inv_y_ff  <= inv_y_in;
         blur_b_ff <= blur_b_in;
         ring_c_ff <= ring_c_in;
      end
   end

   always_ff @(posedge clock) begin
      outer_ff <= outer_in;
      inner_ff <= inner_in;
   end

   assign cfg.inv_x = inv_x_ff;
   assign cfg.inv_y = inv_y_ff;
   assign cfg.outer = outer_ff;
   assign cfg.inner = inner_ff;

endmodule

[design/mfw_front.sv]
module mfw_front import mfw_pkg::*; #(
   parameter int OFFSET_FRAC_BITS = OFFSET_FRAC_BITS_DEF
) (
   input  logic                      req_start,
   input  logic                      full,
   input  logic signed [FIELD_W-1:0] req_dx,
   input  logic signed [FIELD_W-1:0] req_dy,
   input  csr_cfg_type               cfg,
   output logic                      push,
   output qentry_type                entry
);

   localparam int SHIFT = OFFSET_FRAC_BITS + 14 - T_FRAC;
   localparam int FULL_W = 2 * FIELD_W + 1;

   // t = |2 * d * inv|, rescaled to T_FRAC fraction bits and clamped at 2.0.
   function automatic logic [T_W-1:0] scale_t(logic signed [FIELD_W-1:0] d,
                                              logic [FIELD_W-1:0] inv);
      logic [FIELD_W:0]     neg;
      logic [FIELD_W-1:0]   mag;
      logic [2*FIELD_W-1:0] p;
      logic [FULL_W-1:0]    full2;
      logic [FULL_W-1:0]    tt;
      neg   = (FIELD_W+1)'(0) - {d[FIELD_W-1], d};
      mag   = d[FIELD_W-1] ? neg[FIELD_W-1:0] : d;
      p     = mag * inv;
      full2 = {p, 1'b0};
      tt    = full2 >> SHIFT;
      if (tt > FULL_W'(T_MAX)) begin
         return T_MAX;
      end
      return tt[T_W-1:0];
   endfunction

   assign push      = req_start && !full;
   assign entry.t_x = scale_t(req_dx, cfg.inv_x);
   assign entry.t_y = scale_t(req_dy, cfg.inv_y);

endmodule

[design/mfw_queue.sv]
module mfw_queue import mfw_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  qentry_type wr_entry,
   input  logic       pop,
   output logic       full,
   output logic       head_valid,
   output qentry_type head
);

   localparam int PTR_W   = $clog2(DEPTH);
   localparam int COUNT_W = $clog2(DEPTH + 1);

   qentry_type         mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   function automatic logic [PTR_W-1:0] next_ptr(logic [PTR_W-1:0] p);
      if (p == PTR_W'(DEPTH - 1)) begin
         return '0;
      end
      return p + PTR_W'(1);
   endfunction

   assign full       = (count_ff == COUNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + COUNT_W'(push) - COUNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wr_entry;
      end
   end

   // The back end drains one request per cycle, so the queue never holds two.
   a_queue_shallow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(1))
      else $error("request queue holds more than one entry");

endmodule

[design/mfw_back.sv]
module mfw_back import mfw_pkg::*; #(
   parameter int WEIGHT_FRAC_BITS = WEIGHT_FRAC_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      head_valid,
   input  qentry_type                head,
   input  csr_cfg_type               cfg,
   output logic                      pop,
   output logic                      rsp_valid,
   output logic signed [FIELD_W-1:0] rsp_weight
);

   localparam int STAGES = 7;
   localparam int RND_SH = 39 - WEIGHT_FRAC_BITS;
   localparam int OUT_SH = 40 - WEIGHT_FRAC_BITS;
   localparam logic signed [PROD_W-1:0] RND    = PROD_W'(1) << RND_SH;
   localparam logic signed [PROD_W-1:0] W_MAX  = PROD_W'(32767);
   localparam logic signed [PROD_W-1:0] W_MIN  = -PROD_W'(32768);

   logic [STAGES-1:0]        valid_ff, valid_in;

   logic [T_W-1:0]           t1_ff [2],   t1_in [2];
   logic [T2_W-1:0]          t2_1_ff [2], t2_1_in [2];
   logic                     outer1_ff [2], outer1_in [2];

   logic [T3_W-1:0]          t3_2_ff [2], t3_2_in [2];
   logic signed [SUM_W-1:0]  pb2_ff [2],  pb2_in [2];
   logic signed [SUM_W-1:0]  pc2_ff [2],  pc2_in [2];
   logic signed [COEF_W-1:0] a2_ff [2],   a2_in [2];
   logic signed [COEF_W-1:0] dd2_ff [2],  dd2_in [2];

   logic signed [SUM_W-1:0]  pa3_ff [2],   pa3_in [2];
   logic signed [SUM_W-1:0]  rest3_ff [2], rest3_in [2];

   logic [U_W-1:0]           u4_ff [2], u4_in [2];
   logic signed [KV_W-1:0]   k5_ff [2], k5_in [2];

   logic signed [PROD_W-1:0]  prod6_ff, prod6_in;
   logic signed [FIELD_W-1:0] weight_ff, weight_in;

   coef_set_type             cs [2];
   logic signed [SUM_W-1:0]  sum4 [2];
   logic signed [SUM_W-1:0]  sh4 [2];
   logic [2*U_W-1:0]         q5 [2];
   logic [QUOT_W-1:0]        quot5 [2];
   logic signed [PROD_W-1:0] round7;
   logic signed [PROD_W-1:0] scaled7;

   function automatic logic [T2_W-1:0] square_q(logic [T_W-1:0] t);
      logic [2*T_W-1:0] p;
      p = t * t;
      return p[T_FRAC +: T2_W];
   endfunction

   function automatic logic [T3_W-1:0] cube_q(logic [T2_W-1:0] t2, logic [T_W-1:0] t);
      logic [T2_W+T_W-1:0] p;
      p = t2 * t;
      return p[T_FRAC +: T3_W];
   endfunction

   function automatic logic signed [SUM_W-1:0] coef_mul(logic signed [COEF_W-1:0] k,
                                                        logic [T3_W-1:0] v);
      return k * $signed({1'b0, v});
   endfunction

   assign pop        = head_valid;
   assign rsp_valid  = valid_ff[STAGES-1];
   assign rsp_weight = weight_ff;

   always_comb begin
      valid_in = {valid_ff[STAGES-2:0], head_valid};

      t1_in[0] = head.t_x;
      t1_in[1] = head.t_y;
      for (int i = 0; i < 2; i++) begin
         t2_1_in[i]   = square_q(t1_in[i]);
         // Exactly 1.0 stays on the inner piece.
         outer1_in[i] = (t1_in[i] > T_ONE);

         cs[i]      = outer1_ff[i] ? cfg.outer : cfg.inner;
         t3_2_in[i] = cube_q(t2_1_ff[i], t1_ff[i]);
         pb2_in[i]  = coef_mul(cs[i].bb, T3_W'(t2_1_ff[i]));
         pc2_in[i]  = coef_mul(cs[i].cc, T3_W'(t1_ff[i]));
         a2_in[i]   = cs[i].a;
         dd2_in[i]  = cs[i].dd;

         pa3_in[i]   = coef_mul(a2_ff[i], t3_2_ff[i]);
         rest3_in[i] = pb2_ff[i] + pc2_ff[i] + (SUM_W'(dd2_ff[i]) <<< T_FRAC);

         // The biased value is positive, so the divide by three can be unsigned.
         sum4[i]  = pa3_ff[i] + rest3_ff[i];
         sh4[i]   = sum4[i] >>> DIV_SHIFT;
         u4_in[i] = sh4[i][U_W-1:0] + DIV3_BIAS;

         q5[i]    = u4_ff[i] * DIV3_RECIP;
         quot5[i] = q5[i][2*U_W-1:RECIP_SH];
         k5_in[i] = KV_W'(quot5[i] - DIV3_OFFSET);
      end

      prod6_in = k5_ff[0] * k5_ff[1];

      round7  = prod6_ff + RND;
      scaled7 = round7 >>> OUT_SH;
      priority if (scaled7 > W_MAX) begin
         weight_in = FIELD_W'(W_MAX);
      end else if (scaled7 < W_MIN) begin
         weight_in = FIELD_W'(W_MIN);
      end else begin
         weight_in = scaled7[FIELD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 2; i++) begin
         t1_ff[i]     <= t1_in[i];
         t2_1_ff[i]   <= t2_1_in[i];
         outer1_ff[i] <= outer1_in[i];
         t3_2_ff[i]   <= t3_2_in[i];
         pb2_ff[i]    <= pb2_in[i];
         pc2_ff[i]    <= pc2_in[i];
         a2_ff[i]     <= a2_in[i];
         dd2_ff[i]    <= dd2_in[i];
         pa3_ff[i]    <= pa3_in[i];
         rest3_ff[i]  <= rest3_in[i];
         u4_ff[i]     <= u4_in[i];
         k5_ff[i]     <= k5_in[i];
      end
      prod6_ff  <= prod6_in;
      weight_ff <= weight_in;
   end

   // Past 2.0 the kernel is zero on that axis, so the weight must be zero.
   a_outer_edge_zero: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[0] && ((t1_ff[0] == T_MAX) || (t1_ff[1] == T_MAX)))
      |-> ##6 (rsp_weight == '0))
      else $error("weight not zero at the kernel edge");

endmodule

[verif/mfw_checker.sv]
module mfw_checker import mfw_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_start,
   input  logic                      req_busy,
   input  logic signed [FIELD_W-1:0] req_dx,
   input  logic signed [FIELD_W-1:0] req_dy,
   input  logic                      rsp_valid,
   input  logic signed [FIELD_W-1:0] rsp_weight,
   input  logic                      csr_valid,
   input  logic                      csr_ready,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [FIELD_W-1:0]        csr_data,
   output int                        mismatches,
   output int                        outstanding,
   output int                        n_checked
);

   localparam int  MAX_REPORTS = 10;
   localparam longint ONE_Q15  = 32768;

   logic [FIELD_W-1:0]        inv_x_q;
   logic [FIELD_W-1:0]        inv_y_q;
   logic [FIELD_W-1:0]        blur_b_q;
   logic [FIELD_W-1:0]        ring_c_q;
   logic signed [FIELD_W-1:0] weight_fifo[$];

   function automatic longint floor_div(longint num, longint den);
      longint q;
      q = num / den;
      if ((num % den) != 0 && num < 0) begin
         q = q - 1;
      end
      return q;
   endfunction

   // One axis of the separable kernel, returned with 20 fraction bits.
   function automatic longint kernel_axis(longint d, longint inv, longint b, longint c);
      longint mag, t, t2, t3, ca, cb, cc, cd, sum;
      mag = (d < 0) ? -d : d;
      t   = (2 * mag * inv) >> (OFFSET_FRAC_BITS_DEF + 14 - T_FRAC);
      if (t > (longint'(2) << T_FRAC)) begin
         t = longint'(2) << T_FRAC;
      end
      t2 = (t * t) >> T_FRAC;
      t3 = (t2 * t) >> T_FRAC;
      if (t > (longint'(1) << T_FRAC)) begin
         ca = -b - 6 * c;
         cb = 6 * b + 30 * c;
         cc = -12 * b - 48 * c;
         cd = 8 * b + 24 * c;
      end else begin
         ca = 12 * ONE_Q15 - 9 * b - 6 * c;
         cb = -18 * ONE_Q15 + 12 * b + 6 * c;
         cc = 0;
         cd = 6 * ONE_Q15 - 2 * b;
      end
      sum = ca * t3 + cb * t2 + cc * t + cd * (longint'(1) << T_FRAC);
      return floor_div(sum, 6 * 2048);
   endfunction

   function automatic logic signed [FIELD_W-1:0] filter_weight(logic signed [FIELD_W-1:0] dx,
                                                             logic signed [FIELD_W-1:0] dy);
      longint b, c, kx, ky, w;
      b = blur_b_q;
      c = ring_c_q;
      // A zero in either parameter selects the default pair B = C = 1/3.
      if (b == 0 || c == 0) begin
         b = THIRD_Q15;
         c = THIRD_Q15;
      end
      kx = kernel_axis(longint'(dx), inv_x_q, b, c);
      ky = kernel_axis(longint'(dy), inv_y_q, b, c);
      w  = (kx * ky + (longint'(1) << (39 - WEIGHT_FRAC_BITS_DEF)))
           >>> (40 - WEIGHT_FRAC_BITS_DEF);
      if (w > 32767) begin
         w = 32767;
      end
      if (w < -32768) begin
         w = -32768;
      end
      return w[FIELD_W-1:0];
   endfunction

   task automatic report_mismatch(string what, logic signed [FIELD_W-1:0] expected_w);
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
         $display("%0t: %s: expected weight %0d, got %0d", $time, what, expected_w, rsp_weight);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         inv_x_q     = INV_RADIUS_RESET;
         inv_y_q     = INV_RADIUS_RESET;
         blur_b_q    = THIRD_Q15;
         ring_c_q    = THIRD_Q15;
         weight_fifo.delete();
         mismatches  = 0;
         n_checked   = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_idx_type'(csr_index))
               CSR_INV_RADIUS_X: inv_x_q  = csr_data;
               CSR_INV_RADIUS_Y: inv_y_q  = csr_data;
               CSR_BLUR_B:       blur_b_q = csr_data;
               CSR_RING_C:       ring_c_q = csr_data;
               default: ;
            endcase
         end
         if (rsp_valid) begin
            if (weight_fifo.size() == 0) begin
               report_mismatch("weight with no request pending", 'x);
            end else begin
               logic signed [FIELD_W-1:0] expected_w;
               expected_w = weight_fifo.pop_front();
               n_checked++;
               if (rsp_weight !== expected_w) begin
                  report_mismatch("weight mismatch", expected_w);
               end
            end
         end
         if (req_start && !req_busy) begin
            weight_fifo.push_back(filter_weight(req_dx, req_dy));
         end
      end
      outstanding = weight_fifo.size();
   end

endmodule

[verif/tb_mitchell_filter_weight_2d.sv]
module tb_mitchell_filter_weight_2d;
   import mfw_pkg::*;

   localparam int SETTLE_CYCLES  = 12;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_PHASES  = 10;
   localparam int PHASE_ITEMS    = 103;

   logic                      clock;
   logic                      reset;
   logic                      req_start;
   logic                      req_busy;
   logic signed [FIELD_W-1:0] req_dx;
   logic signed [FIELD_W-1:0] req_dy;
   logic                      rsp_valid;
   logic signed [FIELD_W-1:0] rsp_weight;
   logic                      csr_valid;
   logic                      csr_ready;
   csr_idx_type               csr_index;
   logic [FIELD_W-1:0]        csr_data;

   int mismatches;
   int outstanding;
   int n_checked;
   int n_requests;
   int n_csr_writes;
   int quiet_cycles;
   bit burst_mode;

   logic [FIELD_W-1:0] inv_x_now;
   logic [FIELD_W-1:0] inv_y_now;

   mitchell_filter_weight_2d #(
      .OFFSET_FRAC_BITS(OFFSET_FRAC_BITS_DEF),
      .WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS_DEF)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_start  (req_start),
      .req_busy   (req_busy),
      .req_dx     (req_dx),
      .req_dy     (req_dy),
      .rsp_valid  (rsp_valid),
      .rsp_weight (rsp_weight),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   mfw_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_start   (req_start),
      .req_busy    (req_busy),
      .req_dx      (req_dx),
      .req_dy      (req_dy),
      .rsp_valid   (rsp_valid),
      .rsp_weight  (rsp_weight),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .mismatches  (mismatches),
      .outstanding (outstanding),
      .n_checked   (n_checked)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else if ((req_start && !req_busy) || rsp_valid || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_request(logic signed [FIELD_W-1:0] dx, logic signed [FIELD_W-1:0] dy);
      int gap;
      @(negedge clock);
      req_start = 1'b1;
      req_dx    = dx;
      req_dy    = dy;
      @(posedge clock);
      while (req_busy) @(posedge clock);
      n_requests++;
      gap = burst_mode ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         @(negedge clock);
         // Junk on the offsets while start is low must be ignored.
         req_start = 1'b0;
         req_dx    = FIELD_W'($urandom);
         req_dy    = FIELD_W'($urandom);
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_start = 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(csr_idx_type idx, logic [FIELD_W-1:0] value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      n_csr_writes++;
   endtask

   task automatic load_config(logic [FIELD_W-1:0] inv_x, logic [FIELD_W-1:0] inv_y,
                              logic [FIELD_W-1:0] blur_b, logic [FIELD_W-1:0] ring_c);
      drain_results();
      write_csr(CSR_INV_RADIUS_X, inv_x);
      write_csr(CSR_INV_RADIUS_Y, inv_y);
      write_csr(CSR_BLUR_B, blur_b);
      write_csr(CSR_RING_C, ring_c);
      @(negedge clock);
      csr_valid = 1'b0;
      csr_data  = FIELD_W'($urandom);
      // Coefficients are rebuilt the cycle after a write.
      repeat (2) @(negedge clock);
      inv_x_now = inv_x;
      inv_y_now = inv_y;
   endtask

   // Offsets mostly fall inside the kernel support, with extra weight on
   // the t = 1 and t = 2 boundaries and some full-range values.
   function automatic logic signed [FIELD_W-1:0] pick_offset(logic [FIELD_W-1:0] inv);
      longint reach, mag;
      int     sel;
      reach = (inv == 0) ? 32768 : (longint'(1) << 26) / inv;
      if (reach > 32768) begin
         reach = 32768;
      end
      sel = $urandom_range(0, 99);
      if (sel < 15) begin
         return FIELD_W'($urandom);
      end else if (sel < 70) begin
         mag = $urandom_range(0, int'(reach));
      end else if (sel < 85) begin
         mag = reach / 2 + $urandom_range(0, 4) - 2;
      end else begin
         mag = reach + $urandom_range(0, 4) - 2;
      end
      if (mag < 0) begin
         mag = 0;
      end
      if (mag >= 32768) begin
         return 16'sh8000;
      end
      return ($urandom_range(0, 1) == 1) ? FIELD_W'(-mag) : FIELD_W'(mag);
   endfunction

   initial begin
      logic [FIELD_W-1:0] rx, ry, rb, rc;
      reset      = 1'b1;
      req_start  = 1'b0;
      req_dx     = '0;
      req_dy     = '0;
      csr_valid  = 1'b0;
      csr_index  = CSR_INV_RADIUS_X;
      csr_data   = '0;
      burst_mode = 1'b0;
      inv_x_now  = INV_RADIUS_RESET;
      inv_y_now  = INV_RADIUS_RESET;
      n_requests   = 0;
      n_csr_writes = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Reset settings: radius 1, B = C = 1/3, so t = 1 at 0.5 and t = 2 at 1.0.
      send_request(16'sd0, 16'sd0);
      send_request(16'sd2048, 16'sd0);
      send_request(16'sd2049, 16'sd0);
      send_request(-16'sd2048, 16'sd2047);
      send_request(16'sd4096, 16'sd0);
      send_request(16'sd4097, -16'sd5000);
      send_request(16'sd32767, 16'sd32767);
      send_request(-16'sd32768, -16'sd32768);
      send_request(-16'sd32768, 16'sd32767);
      send_request(16'sd21845, -16'sd21846);
      send_request(16'sd1365, -16'sd2731);
      send_request(16'sd3000, 16'sd1000);
      send_request(-16'sd1, 16'sd1);

      // Tiny inverse radii and tiny B, C: the center weight comes out just under 1.0.
      load_config(16'd1, 16'd1, 16'd1, 16'd1);
      send_request(16'sd0, 16'sd0);
      send_request(16'sd32767, -16'sd32768);

      // Zero B falls back to the default pair.
      load_config(16'd16384, 16'd16384, 16'd0, 16'd20000);
      send_request(16'sd0, 16'sd0);
      send_request(16'sd2048, 16'sd3000);

      // Full-scale inverse radii and B = C = 1.0.
      load_config(16'hFFFF, 16'hFFFF, 16'd32768, 16'd32768);
      send_request(16'sd0, 16'sd0);
      send_request(16'sd512, -16'sd513);
      send_request(16'sd700, 16'sd1100);

      // Zero inverse radius pins that axis to the kernel center.
      load_config(16'd0, 16'd8192, 16'd5000, 16'd0);
      send_request(16'sd32767, 16'sd0);
      send_request(-16'sd32768, 16'sd6000);

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: begin
               rx = INV_RADIUS_RESET; ry = INV_RADIUS_RESET; rb = THIRD_Q15; rc = THIRD_Q15;
            end
            1: begin rx = 16'hFFFF; ry = 16'hFFFF; rb = 16'd32768; rc = 16'd32768; end
            2: begin
               rx = 16'd1; ry = FIELD_W'($urandom_range(1, 255)); rb = 16'd1; rc = 16'd32768;
            end
            3: begin
               rx = 16'd16384; ry = 16'd8192; rb = 16'd0;
               rc = FIELD_W'($urandom_range(0, 32768));
            end
            4: begin
               rx = 16'd32768; ry = 16'd5461; rb = FIELD_W'($urandom_range(0, 32768));
               rc = 16'd0;
            end
            default: begin
               rx = ($urandom_range(0, 3) == 0) ? FIELD_W'($urandom_range(1, 65535))
                                                : FIELD_W'($urandom_range(4096, 32768));
               ry = ($urandom_range(0, 3) == 0) ? FIELD_W'($urandom_range(1, 65535))
                                                : FIELD_W'($urandom_range(4096, 32768));
               rb = FIELD_W'($urandom_range(0, 32768));
               rc = FIELD_W'($urandom_range(0, 32768));
            end
         endcase
         load_config(rx, ry, rb, rc);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n % 16 == 0) begin
               burst_mode = ($urandom_range(0, 3) == 0);
            end
            send_request(pick_offset(inv_x_now), pick_offset(inv_y_now));
         end
      end

      drain_results();
      $display("Sent %0d requests across %0d register writes; %0d weights checked.",
               n_requests, n_csr_writes, n_checked);
      $display("Covered kernel center, both cubic pieces, the t = 1 and t = 2 edges, "
               , "B/C fallback, saturation, and zero to full-scale radii.");
      if (mismatches == 0 && outstanding == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

[files.f]
design/mfw_pkg.sv
design/mfw_csr.sv
design/mfw_front.sv
design/mfw_queue.sv
design/mfw_back.sv
design/mitchell_filter_weight_2d.sv
verif/mfw_checker.sv
verif/tb_mitchell_filter_weight_2d.sv
